/* rtl/core/bkrd_pkg.sv */
// Shared constants, types and helpers for the boot keyboard report differ.
`default_nettype none
package bkrd_pkg;

  localparam int KEY_SLOTS_DEFAULT = 6;
  localparam int CODE_W            = 8;
  localparam int LEN_W             = 7;
  localparam int MOD_W             = 8;
  localparam int MOD_EVENTS        = 4;
  localparam int KIND_W            = 2;
  localparam int QUEUE_DEPTH       = 2;
  localparam int OUT_DATA_W        = 16;

  localparam logic [LEN_W-1:0]  MIN_REPORT_BYTES     = 7'd8;
  localparam logic [CODE_W-1:0] HIGHEST_MAPPED_RESET = 8'd70;

  typedef enum logic [KIND_W-1:0] {
    KIND_MODIFIER = 2'd0,
    KIND_KEY      = 2'd1,
    KIND_SYNC     = 2'd2
  } event_kind_t;

  // Modifier bit reported by each modifier event position
  function automatic logic [2:0] mod_bit(input int unsigned idx);
    logic [2:0] bit_idx;
    case (idx)
      0: bit_idx = 3'd0;
      1: bit_idx = 3'd1;
      2: bit_idx = 3'd2;
      default: bit_idx = 3'd5;
    endcase
    return bit_idx;
  endfunction

  function automatic int job_width(input int key_slots);
    return 2 * MOD_EVENTS + 2 * key_slots * (CODE_W + 1);
  endfunction

  function automatic int in_data_width(input int key_slots);
    return ((LEN_W + MOD_W + CODE_W * key_slots + 7) / 8) * 8;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/bkrd_queue.sv */
// Short job queue between the classifying front and the event back end.
`default_nettype none
module bkrd_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  localparam int DEPTH = bkrd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bkrd_front.sv */
// Front end: accepts reports, compares them with stored state and builds event jobs.
`default_nettype none
module bkrd_front #(
  parameter int KEY_SLOTS = bkrd_pkg::KEY_SLOTS_DEFAULT,
  localparam int JOB_W  = bkrd_pkg::job_width(KEY_SLOTS),
  localparam int IN_W   = bkrd_pkg::in_data_width(KEY_SLOTS)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [IN_W-1:0]                 s_tdata,
  input  wire logic                            cfg_wen,
  input  wire logic [bkrd_pkg::CODE_W-1:0]     cfg_wdata,
  output logic                                 job_valid,
  input  wire logic                            job_ready,
  output logic [JOB_W-1:0]                     job_data
);

  localparam int CW = bkrd_pkg::CODE_W;
  localparam int LW = bkrd_pkg::LEN_W;
  localparam int MW = bkrd_pkg::MOD_W;
  localparam int ME = bkrd_pkg::MOD_EVENTS;

  logic [CW-1:0]        highest_mapped_code;
  logic [MW-1:0]        prev_mods;
  logic [CW-1:0]        last_keys [KEY_SLOTS];

  logic [LW-1:0]        length;
  logic [MW-1:0]        mods;
  logic [CW-1:0]        keys [KEY_SLOTS];
  logic [ME-1:0]        mod_chg;
  logic [ME-1:0]        mod_val;
  logic [KEY_SLOTS-1:0] release_mask;
  logic [KEY_SLOTS-1:0] press_mask;
  logic [CW*KEY_SLOTS-1:0] prev_flat;
  logic [CW*KEY_SLOTS-1:0] new_flat;
  logic                 full_report;
  logic                 accept;

  always_comb begin
    logic [MW-1:0] changed;
    logic          hit_new;
    logic          hit_prev;
    length = s_tdata[LW-1:0];
    mods   = s_tdata[LW +: MW];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      keys[i] = s_tdata[LW + MW + CW * i +: CW];
    end
    changed = mods ^ prev_mods;
    for (int i = 0; i < ME; i++) begin
      mod_chg[i] = changed[bkrd_pkg::mod_bit(i)];
      mod_val[i] = mods[bkrd_pkg::mod_bit(i)];
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit_new  = 1'b0;
      hit_prev = 1'b0;
      for (int m = 0; m < KEY_SLOTS; m++) begin
        hit_new  = hit_new  || (keys[m] == last_keys[i]);
        hit_prev = hit_prev || (last_keys[m] == keys[i]);
      end
      release_mask[i] = (last_keys[i] != '0) && (last_keys[i] <= highest_mapped_code)
                        && !hit_new;
      press_mask[i]   = (keys[i] != '0) && (keys[i] <= highest_mapped_code) && !hit_prev;
      prev_flat[CW * i +: CW] = last_keys[i];
      new_flat[CW * i +: CW]  = keys[i];
    end
  end

  assign full_report = (length >= bkrd_pkg::MIN_REPORT_BYTES);
  assign s_tready    = job_ready;
  assign job_valid   = s_tvalid && full_report;
  assign accept      = s_tvalid && s_tready && full_report;
  assign job_data    = {press_mask, new_flat, release_mask, prev_flat, mod_val, mod_chg};

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_mapped_code <= bkrd_pkg::HIGHEST_MAPPED_RESET;
      prev_mods           <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        last_keys[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        highest_mapped_code <= cfg_wdata;
      end
      if (accept) begin
        prev_mods <= mods;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          last_keys[i] <= keys[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bkrd_back.sv */
// Back end: walks the pending events of a job and drives the registered event stream.
`default_nettype none
module bkrd_back #(
  parameter int KEY_SLOTS = bkrd_pkg::KEY_SLOTS_DEFAULT,
  localparam int JOB_W = bkrd_pkg::job_width(KEY_SLOTS)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              job_valid,
  output logic                                   job_ready,
  input  wire logic [JOB_W-1:0]                  job_data,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [bkrd_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic [bkrd_pkg::KIND_W-1:0]            m_tuser,
  output logic                                   m_tlast
);

  localparam int CW  = bkrd_pkg::CODE_W;
  localparam int ME  = bkrd_pkg::MOD_EVENTS;
  localparam int KB  = CW * KEY_SLOTS;
  localparam int NEV = ME + 2 * KEY_SLOTS + 1;
  localparam int O_VAL  = ME;
  localparam int O_PREV = 2 * ME;
  localparam int O_REL  = O_PREV + KB;
  localparam int O_NEW  = O_REL + KEY_SLOTS;
  localparam int O_PRS  = O_NEW + KB;

  logic [NEV-1:0]        pending;
  logic [NEV-1:0]        pending_next;
  logic [ME-1:0]         mod_val;
  logic [KB-1:0]         prev_codes;
  logic [KB-1:0]         new_codes;

  logic [NEV-1:0]        sel;
  logic                  busy;
  logic                  final_event;
  logic                  out_free;
  logic                  adv;
  logic                  load;

  bkrd_pkg::event_kind_t ev_kind;
  logic [CW-1:0]         ev_code;
  logic                  ev_pressed;
  logic                  ev_last;

  bkrd_pkg::event_kind_t out_kind;
  logic [CW-1:0]         out_code;
  logic                  out_pressed;
  logic                  out_last;

  assign sel         = pending & (~pending + 1'b1);
  assign busy        = (pending != '0);
  assign final_event = (pending == sel);
  assign out_free    = !m_tvalid || m_tready;
  assign adv         = busy && out_free;
  assign job_ready   = !busy || (adv && final_event);
  assign load        = job_valid && job_ready;

  always_comb begin
    ev_kind    = bkrd_pkg::KIND_SYNC;
    ev_code    = '0;
    ev_pressed = 1'b0;
    ev_last    = 1'b0;
    for (int i = 0; i < ME; i++) begin
      if (sel[i]) begin
        ev_kind    = bkrd_pkg::KIND_MODIFIER;
        ev_code    = CW'(bkrd_pkg::mod_bit(i));
        ev_pressed = mod_val[i];
      end
    end
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (sel[ME + j]) begin
        ev_kind    = bkrd_pkg::KIND_KEY;
        ev_code    = prev_codes[CW * j +: CW];
        ev_pressed = 1'b0;
      end
      if (sel[ME + KEY_SLOTS + j]) begin
        ev_kind    = bkrd_pkg::KIND_KEY;
        ev_code    = new_codes[CW * j +: CW];
        ev_pressed = 1'b1;
      end
    end
    if (sel[NEV-1]) begin
      ev_kind    = bkrd_pkg::KIND_SYNC;
      ev_code    = '0;
      ev_pressed = 1'b0;
      ev_last    = 1'b1;
    end
  end

  always_comb begin
    pending_next = pending;
    if (load) begin
      pending_next = {1'b1, job_data[O_PRS +: KEY_SLOTS], job_data[O_REL +: KEY_SLOTS],
                      job_data[0 +: ME]};
    end else if (adv) begin
      pending_next = pending & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mod_val    <= job_data[O_VAL +: ME];
      prev_codes <= job_data[O_PREV +: KB];
      new_codes  <= job_data[O_NEW +: KB];
    end
    if (adv) begin
      out_kind    <= ev_kind;
      out_code    <= ev_code;
      out_pressed <= ev_pressed;
      out_last    <= ev_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      pending <= pending_next;
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(bkrd_pkg::OUT_DATA_W - CW - 1){1'b0}}, out_pressed, out_code};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule
`default_nettype wire

/* rtl/core/boot_keyboard_report_diff.sv */
// Top level of the boot keyboard report differ: front end, job queue and event back end.
// A full report is queued, loaded into the back end, then its first event is registered.
// Throughput: one event per cycle while m_tready is high; a report with N changes gives
// N + 1 events (1 to 17 for six slots) from the back end's single event register.
// A short report is taken when s_tready is high, but queues no job and gives no event.
// Reset: stored modifiers and keys cleared to zero, threshold set to 70, queue emptied.
`default_nettype none
module boot_keyboard_report_diff #(
  parameter int KEY_SLOTS = bkrd_pkg::KEY_SLOTS_DEFAULT
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  // tdata: report_length, modifier_byte, key_slot_0 .. key_slot_N, zero fill
  input  wire logic                                          s_tvalid,
  output logic                                               s_tready,
  input  wire logic [bkrd_pkg::in_data_width(KEY_SLOTS)-1:0] s_tdata,
  // tdata: event_code, is_pressed, zero fill; tuser: event_kind; tlast: last_of_run
  output logic                                               m_tvalid,
  input  wire logic                                          m_tready,
  output logic [bkrd_pkg::OUT_DATA_W-1:0]                    m_tdata,
  output logic [bkrd_pkg::KIND_W-1:0]                        m_tuser,
  output logic                                               m_tlast,
  input  wire logic                                          cfg_wen,
  input  wire logic [bkrd_pkg::CODE_W-1:0]                   cfg_wdata
);

  localparam int JOB_W = bkrd_pkg::job_width(KEY_SLOTS);

  logic             fq_valid;
  logic             fq_ready;
  logic [JOB_W-1:0] fq_data;
  logic             qb_valid;
  logic             qb_ready;
  logic [JOB_W-1:0] qb_data;

  bkrd_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job_data  (fq_data)
  );

  bkrd_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  bkrd_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire
